// File: design/rcr_pkg.sv
// ----------------------------------------------------------------------------
// rcr_pkg
// Shared constants and codes for the rectangle canvas rasterizer.
// ----------------------------------------------------------------------------
package rcr_pkg;

   localparam int MAX_SIDE  = 256;
   localparam int FRAC_BITS = 8;

   localparam int FIELD_W   = 20;
   localparam int CHAR_W    = 8;
   localparam int POS_W     = 8;
   localparam int OP_W      = 2;
   localparam int SIDE_W    = 9;
   localparam int COORD_W   = $clog2(MAX_SIDE);
   localparam int ADDR_W    = 2 * COORD_W;
   localparam int SUM_W     = FIELD_W + 1;
   localparam int CRD_S_W   = SUM_W - FRAC_BITS;

   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
   localparam logic [OP_W-1:0] OP_OUTLINE = 2'd1;
   localparam logic [OP_W-1:0] OP_FILLED  = 2'd2;
   localparam logic [OP_W-1:0] OP_READ    = 2'd3;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_BG     = 2'd2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [SIDE_W-1:0] WIDTH_RESET  = 9'd1;
   localparam logic [SIDE_W-1:0] HEIGHT_RESET = 9'd1;
   localparam logic [CHAR_W-1:0] BG_RESET     = 8'd32;

   localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

endpackage

// File: design/rcr_if.sv
// ----------------------------------------------------------------------------
// rcr request and response channels
// Valid/ready channels carrying rasterizer items and their results.
// ----------------------------------------------------------------------------
interface rcr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [rcr_pkg::OP_W-1:0]        operation;
   logic signed [rcr_pkg::FIELD_W-1:0]     left_x;
   logic signed [rcr_pkg::FIELD_W-1:0]     top_y;
   logic signed [rcr_pkg::FIELD_W-1:0]     rect_width;
   logic signed [rcr_pkg::FIELD_W-1:0]     rect_height;
   logic        [rcr_pkg::CHAR_W-1:0]      paint_char;
   logic        [rcr_pkg::POS_W-1:0]       read_col;
   logic        [rcr_pkg::POS_W-1:0]       read_row;

   modport source (output valid, operation, left_x, top_y, rect_width, rect_height,
                   paint_char, read_col, read_row, input ready);
   modport sink   (input valid, operation, left_x, top_y, rect_width, rect_height,
                   paint_char, read_col, read_row, output ready);
endinterface

interface rcr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rcr_pkg::CHAR_W-1:0]        pixel_value;
   logic                              status;

   modport source (output valid, pixel_value, status, input ready);
   modport sink   (input valid, pixel_value, status, output ready);
endinterface

// File: design/rectangle_canvas_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// rectangle_canvas_rasterizer_unit
// Character canvas with clear, outline/filled rectangle drawing and pixel read.
// ----------------------------------------------------------------------------
// One item at a time. A clear writes every pixel of the canvas, one pixel write
// per cycle into the canvas memory. A rectangle computes its edges on the
// shared adder, clips them, then walks every pixel of its clipped bounding box,
// writing only the edge pixels for an outline. A read goes through the READ and
// RWAIT states; a read outside the canvas and a rejected rectangle go straight to
// the result, an empty one after clipping. A result that is not taken holds the
// next item in its done state until it is. The canvas is not cleared by reset.
module rectangle_canvas_rasterizer_unit (
   input  logic                               clock,
   input  logic                               reset,
   rcr_req_if.sink                            req_bus,
   rcr_rsp_if.source                          rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rcr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rcr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rcr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ADD   = 3'd1;
   localparam logic [2:0] ST_CLIP  = 3'd2;
   localparam logic [2:0] ST_DRAW  = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_RWAIT = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   localparam int FW = rcr_pkg::FIELD_W;
   localparam int CW = rcr_pkg::COORD_W;
   localparam int SW = rcr_pkg::CRD_S_W;
   localparam logic [FW-1:0] ROUND_UP = FW'((1 << rcr_pkg::FRAC_BITS) - 1);

   // configuration registers
   logic [rcr_pkg::SIDE_W-1:0] width_ff, height_ff;
   logic [rcr_pkg::CHAR_W-1:0] bg_ff;
   logic [1:0]                 csr_index;
   logic                       csr_write;

   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rcr_pkg::WIDTH_RESET;
         height_ff <= rcr_pkg::HEIGHT_RESET;
         bg_ff     <= rcr_pkg::BG_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            rcr_pkg::REG_WIDTH:  width_ff  <= csr_pwdata[rcr_pkg::SIDE_W-1:0];
            rcr_pkg::REG_HEIGHT: height_ff <= csr_pwdata[rcr_pkg::SIDE_W-1:0];
            rcr_pkg::REG_BG:     bg_ff     <= csr_pwdata[rcr_pkg::CHAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         rcr_pkg::REG_WIDTH:  csr_prdata = rcr_pkg::CSR_DATA_W'(width_ff);
         rcr_pkg::REG_HEIGHT: csr_prdata = rcr_pkg::CSR_DATA_W'(height_ff);
         rcr_pkg::REG_BG:     csr_prdata = rcr_pkg::CSR_DATA_W'(bg_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // effective canvas size
   logic [rcr_pkg::SIDE_W-1:0] w_eff, h_eff;
   assign w_eff = (width_ff  > rcr_pkg::SIDE_MAX) ? rcr_pkg::SIDE_MAX : width_ff;
   assign h_eff = (height_ff > rcr_pkg::SIDE_MAX) ? rcr_pkg::SIDE_MAX : height_ff;

   // item registers
   logic [2:0]                     state_ff, state_in;
   logic [1:0]                     step_ff, step_in;
   logic signed [FW-1:0]           lx_ff, ty_ff, rw_ff, rh_ff;
   logic [rcr_pkg::CHAR_W-1:0]     char_ff, char_in;
   logic [rcr_pkg::POS_W-1:0]      col_ff, row_ff;
   logic                           filled_ff, filled_in;
   logic signed [SW-1:0]           x0_ff, x1_ff, y0_ff, y1_ff;
   logic [CW-1:0]                  lo_x_ff, lo_x_in, hi_x_ff, hi_x_in;
   logic [CW-1:0]                  hi_y_ff, hi_y_in;
   logic [CW-1:0]                  x_ff, x_in, y_ff, y_in;
   logic [rcr_pkg::CHAR_W-1:0]     res_pixel_ff, res_pixel_in;
   logic                           res_status_ff, res_status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rcr_pkg::CHAR_W-1:0]     rsp_pixel_ff;
   logic                           rsp_status_ff;
   logic                           accept, rsp_load;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   // shared adder for the rectangle edges
   logic signed [FW-1:0]           add_a, add_b;
   logic signed [rcr_pkg::SUM_W-1:0] add_sum;
   logic signed [SW-1:0]           add_crd;

   always_comb begin
      case (step_ff)
         2'd0:    begin add_a = lx_ff; add_b = ROUND_UP; end
         2'd1:    begin add_a = lx_ff; add_b = rw_ff;    end
         2'd2:    begin add_a = ty_ff; add_b = ROUND_UP; end
         default: begin add_a = ty_ff; add_b = rh_ff;    end
      endcase
   end

   assign add_sum = {add_a[FW-1], add_a} + {add_b[FW-1], add_b};
   assign add_crd = add_sum[rcr_pkg::SUM_W-1 -: SW];

   always_ff @(posedge clock) begin
      if (state_ff == ST_ADD) begin
         case (step_ff)
            2'd0:    x0_ff <= add_crd;
            2'd1:    x1_ff <= add_crd;
            2'd2:    y0_ff <= add_crd;
            default: y1_ff <= add_crd;
         endcase
      end
   end

   // clipping
   logic signed [SW-1:0] wm1, hm1, cx0, cx1, cy0, cy1;
   logic                 clip_empty;

   assign wm1 = $signed(SW'(w_eff)) - $signed(SW'(1));
   assign hm1 = $signed(SW'(h_eff)) - $signed(SW'(1));
   assign cx0 = x0_ff[SW-1] ? '0 : x0_ff;
   assign cy0 = y0_ff[SW-1] ? '0 : y0_ff;
   assign cx1 = (x1_ff > wm1) ? wm1 : x1_ff;
   assign cy1 = (y1_ff > hm1) ? hm1 : y1_ff;
   assign clip_empty = (cx0 > cx1) || (cy0 > cy1);

   // canvas memory
   logic [rcr_pkg::CHAR_W-1:0] canvas_mem [0:(1 << rcr_pkg::ADDR_W)-1];
   logic [rcr_pkg::CHAR_W-1:0] rd_data_ff;
   logic                       on_edge, mem_we;

   assign on_edge = (x0_ff == SW'(x_ff)) || (x1_ff == SW'(x_ff)) ||
                    (y0_ff == SW'(y_ff)) || (y1_ff == SW'(y_ff));
   assign mem_we  = (state_ff == ST_DRAW) && (filled_ff || on_edge);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         canvas_mem[{y_ff, x_ff}] <= char_ff;
      end
      rd_data_ff <= canvas_mem[{row_ff[CW-1:0], col_ff[CW-1:0]}];
   end

   // sequencer
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      char_in       = char_ff;
      filled_in     = filled_ff;
      lo_x_in       = lo_x_ff;
      hi_x_in       = hi_x_ff;
      hi_y_in       = hi_y_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      res_pixel_in  = res_pixel_ff;
      res_status_in = res_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_pixel_in  = '0;
               res_status_in = 1'b0;
               step_in       = '0;
               case (req_bus.operation) inside
                  rcr_pkg::OP_CLEAR: begin
                     char_in   = bg_ff;
                     filled_in = 1'b1;
                     lo_x_in   = '0;
                     hi_x_in   = CW'(w_eff - 1'b1);
                     hi_y_in   = CW'(h_eff - 1'b1);
                     x_in      = '0;
                     y_in      = '0;
                     state_in  = (w_eff == '0 || h_eff == '0) ? ST_DONE : ST_DRAW;
                  end
                  rcr_pkg::OP_OUTLINE, rcr_pkg::OP_FILLED: begin
                     char_in   = req_bus.paint_char;
                     filled_in = (req_bus.operation == rcr_pkg::OP_FILLED);
                     if (req_bus.rect_width <= 0 || req_bus.rect_height <= 0) begin
                        res_status_in = 1'b1;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_ADD;
                     end
                  end
                  default: begin
                     if ({1'b0, req_bus.read_col} < w_eff &&
                         {1'b0, req_bus.read_row} < h_eff) begin
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
               endcase
            end
         end
         ST_ADD: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = ST_CLIP;
            end
         end
         ST_CLIP: begin
            lo_x_in = cx0[CW-1:0];
            hi_x_in = cx1[CW-1:0];
            hi_y_in = cy1[CW-1:0];
            x_in    = cx0[CW-1:0];
            y_in    = cy0[CW-1:0];
            state_in = clip_empty ? ST_DONE : ST_DRAW;
         end
         ST_DRAW: begin
            if (x_ff == hi_x_ff) begin
               x_in = lo_x_ff;
               y_in = y_ff + 1'b1;
               if (y_ff == hi_y_ff) begin
                  state_in = ST_DONE;
               end
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         ST_READ: begin
            state_in = ST_RWAIT;
         end
         ST_RWAIT: begin
            res_pixel_in = rd_data_ff;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lx_ff  <= req_bus.left_x;
         ty_ff  <= req_bus.top_y;
         rw_ff  <= req_bus.rect_width;
         rh_ff  <= req_bus.rect_height;
         col_ff <= req_bus.read_col;
         row_ff <= req_bus.read_row;
      end
      char_ff       <= char_in;
      filled_ff     <= filled_in;
      lo_x_ff       <= lo_x_in;
      hi_x_ff       <= hi_x_in;
      hi_y_ff       <= hi_y_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      res_pixel_ff  <= res_pixel_in;
      res_status_ff <= res_status_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pixel_ff  <= res_pixel_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pixel_value = rsp_pixel_ff;
   assign rsp_bus.status      = rsp_status_ff;

endmodule

// File: design/rcr_checker.sv
// ----------------------------------------------------------------------------
// rcr_checker
// Port-level checks for the rectangle canvas rasterizer.
// ----------------------------------------------------------------------------
module rcr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rcr_pkg::CHAR_W-1:0]   rsp_pixel_value,
   input logic                         rsp_status,
   input logic                         csr_pready
);

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready high right after an item was taken");

   a_reject_no_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_pixel_value == '0))
      else $error("rejected rectangle carries a pixel value");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel_value) &&
                                     $stable(rsp_status)))
      else $error("stalled result changed");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule

bind rectangle_canvas_rasterizer_unit rcr_checker u_rcr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_pixel_value (rsp_bus.pixel_value),
   .rsp_status      (rsp_bus.status),
   .csr_pready      (csr_pready)
);

// File: verif/tb_rectangle_canvas_rasterizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rectangle_canvas_rasterizer_unit
// Self-checking bench for the rectangle canvas rasterizer. A clocked driver
// feeds clear, outline, filled and read items from a queue. Bursts and gaps
// are random. A clocked monitor stalls the result channel on a pattern of its
// own and compares every pixel and status against a mirror canvas. The mirror
// is updated as each item is accepted. Canvas settings change between phases
// over the APB port, from a one-pixel canvas up to the full and oversized
// sizes, and an empty canvas.
// ----------------------------------------------------------------------------
module tb_rectangle_canvas_rasterizer_unit;

   localparam int WATCHDOG_LIMIT  = 300000;
   localparam int LONG_HOLD       = 2500;
   localparam int ITEMS_PER_PHASE = 48;
   localparam int RANDOM_PHASES   = 12;
   localparam int FRAC_ONE        = 1 << rcr_pkg::FRAC_BITS;

   typedef struct {
      logic [rcr_pkg::OP_W-1:0]           operation;
      logic signed [rcr_pkg::FIELD_W-1:0] left_x;
      logic signed [rcr_pkg::FIELD_W-1:0] top_y;
      logic signed [rcr_pkg::FIELD_W-1:0] rect_width;
      logic signed [rcr_pkg::FIELD_W-1:0] rect_height;
      logic [rcr_pkg::CHAR_W-1:0]         paint_char;
      logic [rcr_pkg::POS_W-1:0]          read_col;
      logic [rcr_pkg::POS_W-1:0]          read_row;
   } raster_item_type;

   typedef struct {
      logic [rcr_pkg::CHAR_W-1:0] pixel_value;
      logic                       status;
   } pixel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [rcr_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [rcr_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [rcr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   rcr_req_if req_bus ();
   rcr_rsp_if rsp_bus ();

   rectangle_canvas_rasterizer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   raster_item_type  draw_queue[$];
   pixel_result_type expected_pixels[$];

   logic [rcr_pkg::CHAR_W-1:0] canvas_mirror [rcr_pkg::MAX_SIDE*rcr_pkg::MAX_SIDE];
   logic [rcr_pkg::SIDE_W-1:0] cols_reg;
   logic [rcr_pkg::SIDE_W-1:0] rows_reg;
   logic [rcr_pkg::CHAR_W-1:0] bg_reg;

   int failures     = 0;
   int results_seen = 0;

   int phase_cols [8] = '{8, 0, 511, 3, 1, 24, 256, 1};
   int phase_rows [8] = '{8, 7, 2, 300, 1, 20, 1, 256};

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.operation   = rcr_pkg::OP_CLEAR;
      req_bus.left_x      = '0;
      req_bus.top_y       = '0;
      req_bus.rect_width  = '0;
      req_bus.rect_height = '0;
      req_bus.paint_char  = '0;
      req_bus.read_col    = '0;
      req_bus.read_row    = '0;
      rsp_bus.ready       = 1'b0;
   end

   function automatic longint side_in_use(input logic [rcr_pkg::SIDE_W-1:0] r);
      return (r > rcr_pkg::SIDE_MAX) ? longint'(rcr_pkg::MAX_SIDE) : longint'(r);
   endfunction

   function automatic void rasterize_item(input raster_item_type it);
      longint           cols, rows, lx, ty, rw, rh;
      longint           x0, y0, x1, y1, xa, ya, xb, yb, x, y;
      pixel_result_type res;
      cols = side_in_use(cols_reg);
      rows = side_in_use(rows_reg);
      res.pixel_value = '0;
      res.status      = 1'b0;
      case (it.operation) inside
         rcr_pkg::OP_CLEAR: begin
            for (y = 0; y < rows; y++)
               for (x = 0; x < cols; x++)
                  canvas_mirror[int'(y * rcr_pkg::MAX_SIDE + x)] = bg_reg;
         end
         rcr_pkg::OP_OUTLINE, rcr_pkg::OP_FILLED: begin
            lx = it.left_x;
            ty = it.top_y;
            rw = it.rect_width;
            rh = it.rect_height;
            if (rw <= 0 || rh <= 0) begin
               res.status = 1'b1;
            end else begin
               // ceiling of the origin, floor of the far edge
               x0 = -((-lx) >>> rcr_pkg::FRAC_BITS);
               y0 = -((-ty) >>> rcr_pkg::FRAC_BITS);
               x1 = (lx + rw) >>> rcr_pkg::FRAC_BITS;
               y1 = (ty + rh) >>> rcr_pkg::FRAC_BITS;
               xa = (x0 < 0) ? 0 : x0;
               ya = (y0 < 0) ? 0 : y0;
               xb = (x1 > cols - 1) ? cols - 1 : x1;
               yb = (y1 > rows - 1) ? rows - 1 : y1;
               for (y = ya; y <= yb; y++)
                  for (x = xa; x <= xb; x++)
                     if (it.operation == rcr_pkg::OP_FILLED || x == x0 || x == x1 ||
                         y == y0 || y == y1)
                        canvas_mirror[int'(y * rcr_pkg::MAX_SIDE + x)] = it.paint_char;
            end
         end
         rcr_pkg::OP_READ: begin
            if (longint'(it.read_col) < cols && longint'(it.read_row) < rows)
               res.pixel_value = canvas_mirror[int'(it.read_row) * rcr_pkg::MAX_SIDE +
                                               int'(it.read_col)];
         end
         default: ;
      endcase
      expected_pixels.push_back(res);
   endfunction

   function automatic raster_item_type random_fields();
      raster_item_type it;
      it.operation   = rcr_pkg::OP_W'($urandom);
      it.left_x      = rcr_pkg::FIELD_W'($urandom);
      it.top_y       = rcr_pkg::FIELD_W'($urandom);
      it.rect_width  = rcr_pkg::FIELD_W'($urandom);
      it.rect_height = rcr_pkg::FIELD_W'($urandom);
      it.paint_char  = rcr_pkg::CHAR_W'($urandom);
      it.read_col    = rcr_pkg::POS_W'($urandom);
      it.read_row    = rcr_pkg::POS_W'($urandom);
      return it;
   endfunction

   function automatic raster_item_type clear_item();
      raster_item_type it;
      it = random_fields();
      it.operation = rcr_pkg::OP_CLEAR;
      return it;
   endfunction

   function automatic raster_item_type read_item(input int col, input int row);
      raster_item_type it;
      it = random_fields();
      it.operation = rcr_pkg::OP_READ;
      it.read_col  = rcr_pkg::POS_W'(col);
      it.read_row  = rcr_pkg::POS_W'(row);
      return it;
   endfunction

   function automatic raster_item_type rect_item(input logic [rcr_pkg::OP_W-1:0] op,
                                                 input int lx, input int ty,
                                                 input int rw, input int rh,
                                                 input int ch);
      raster_item_type it;
      it = random_fields();
      it.operation   = op;
      it.left_x      = rcr_pkg::FIELD_W'(lx);
      it.top_y       = rcr_pkg::FIELD_W'(ty);
      it.rect_width  = rcr_pkg::FIELD_W'(rw);
      it.rect_height = rcr_pkg::FIELD_W'(rh);
      it.paint_char  = rcr_pkg::CHAR_W'(ch);
      return it;
   endfunction

   function automatic int q_frac();
      return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, FRAC_ONE - 1));
   endfunction

   function automatic int q_coord(input int side);
      return (int'($urandom_range(0, side + 8)) - 4) * FRAC_ONE + q_frac();
   endfunction

   function automatic int q_size(input int side);
      int v;
      v = int'($urandom_range(0, side + 4)) * FRAC_ONE + q_frac();
      return (v == 0) ? 1 : v;
   endfunction

   function automatic raster_item_type random_item(input int cols, input int rows);
      raster_item_type it;
      int              sel;
      int              shape;
      it  = random_fields();
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
         it.operation = rcr_pkg::OP_CLEAR;
      end else if (sel < 70) begin
         it.operation = (sel < 40) ? rcr_pkg::OP_OUTLINE : rcr_pkg::OP_FILLED;
         shape = $urandom_range(0, 9);
         if (shape != 0) begin
            it.left_x      = rcr_pkg::FIELD_W'(q_coord(cols));
            it.top_y       = rcr_pkg::FIELD_W'(q_coord(rows));
            it.rect_width  = rcr_pkg::FIELD_W'(q_size(cols));
            it.rect_height = rcr_pkg::FIELD_W'(q_size(rows));
            // non-positive sizes
            if (shape == 1 || shape == 3)
               it.rect_width = rcr_pkg::FIELD_W'(-int'($urandom_range(0, 3000)));
            if (shape == 2 || shape == 3)
               it.rect_height = rcr_pkg::FIELD_W'(-int'($urandom_range(0, 3000)));
         end
      end else begin
         it.operation = rcr_pkg::OP_READ;
         if ($urandom_range(0, 9) != 0) begin
            it.read_col = rcr_pkg::POS_W'($urandom_range(0, cols));
            it.read_row = rcr_pkg::POS_W'($urandom_range(0, rows));
         end
      end
      return it;
   endfunction

   task automatic write_csr(input logic [1:0] idx, input int value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= rcr_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= rcr_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         rcr_pkg::REG_WIDTH:  cols_reg = rcr_pkg::SIDE_W'(value);
         rcr_pkg::REG_HEIGHT: rows_reg = rcr_pkg::SIDE_W'(value);
         rcr_pkg::REG_BG:     bg_reg   = rcr_pkg::CHAR_W'(value);
         default: ;
      endcase
   endtask

   task automatic drain();
      while (draw_queue.size() != 0 || req_bus.valid || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input int cols, input int rows, input int bg);
      drain();
      write_csr(rcr_pkg::REG_WIDTH, cols);
      write_csr(rcr_pkg::REG_HEIGHT, rows);
      write_csr(rcr_pkg::REG_BG, bg);
   endtask

   // driver
   raster_item_type on_bus;
   int              burst_left = 0;
   int              gap_left   = 0;

   always @(posedge clock) begin
      logic offer_next;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         offer_next = !req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            rasterize_item(on_bus);
            offer_next = 1'b1;
         end
         if (offer_next) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (draw_queue.size() != 0) begin
               on_bus = draw_queue.pop_front();
               req_bus.operation   <= on_bus.operation;
               req_bus.left_x      <= on_bus.left_x;
               req_bus.top_y       <= on_bus.top_y;
               req_bus.rect_width  <= on_bus.rect_width;
               req_bus.rect_height <= on_bus.rect_height;
               req_bus.paint_char  <= on_bus.paint_char;
               req_bus.read_col    <= on_bus.read_col;
               req_bus.read_row    <= on_bus.read_row;
               req_bus.valid       <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor and result stall pattern
   int stall_cycle = 0;
   int hold_left   = 0;

   always @(posedge clock) begin
      pixel_result_type want;
      logic             ready_next;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("result with nothing expected: pixel %02h status %0b",
                           rsp_bus.pixel_value, rsp_bus.status);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_bus.pixel_value !== want.pixel_value ||
                   rsp_bus.status !== want.status) begin
                  failures++;
                  if (failures <= 10)
                     $display({"result %0d: expected pixel %02h status %0b, ",
                               "got pixel %02h status %0b"},
                              results_seen, want.pixel_value, want.status,
                              rsp_bus.pixel_value, rsp_bus.status);
               end
            end
            if (results_seen == 150 || results_seen == 400)
               hold_left = LONG_HOLD;
         end
         stall_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case ((stall_cycle / 300) % 4)
               0:       ready_next = 1'b1;
               1:       ready_next = 1'($urandom_range(0, 1));
               2:       ready_next = ($urandom_range(0, 3) == 0);
               default: ready_next = (stall_cycle % 7) < 3;
            endcase
         end
         rsp_bus.ready <= ready_next;
      end
   end

   // watchdog
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL rectangle_canvas_rasterizer_unit");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int cols;
      int rows;
      int bg;
      int p;
      int k;
      cols_reg = rcr_pkg::WIDTH_RESET;
      rows_reg = rcr_pkg::HEIGHT_RESET;
      bg_reg   = rcr_pkg::BG_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one-pixel canvas after reset
      draw_queue.push_back(clear_item());
      draw_queue.push_back(read_item(0, 0));
      draw_queue.push_back(read_item(1, 0));
      draw_queue.push_back(read_item(0, 1));

      configure(16, 12, 8'h23);
      draw_queue.push_back(clear_item());
      draw_queue.push_back(rect_item(rcr_pkg::OP_FILLED, -589, -256, 25600, 25600, 8'h00));
      draw_queue.push_back(rect_item(rcr_pkg::OP_OUTLINE, 384, -128, 2624, 1536, 8'h72));
      draw_queue.push_back(rect_item(rcr_pkg::OP_OUTLINE, -256, 1984, 5120, 896, 8'hFF));
      // far edge just below the first pixel
      draw_queue.push_back(rect_item(rcr_pkg::OP_FILLED, -524288, -524288, 524287, 524287,
                                     8'h52));
      // rejected sizes
      draw_queue.push_back(rect_item(rcr_pkg::OP_FILLED, 512, 768, 0, 256, 8'h41));
      draw_queue.push_back(rect_item(rcr_pkg::OP_OUTLINE, 512, 768, 256, -1, 8'h42));
      draw_queue.push_back(rect_item(rcr_pkg::OP_FILLED, 0, 0, -524288, 524287, 8'h43));
      // span shorter than one pixel, origin far outside
      draw_queue.push_back(rect_item(rcr_pkg::OP_OUTLINE, 384, 0, 64, 512, 8'h44));
      draw_queue.push_back(rect_item(rcr_pkg::OP_FILLED, 524287, 0, 524287, 1024, 8'h45));
      draw_queue.push_back(read_item(0, 0));
      draw_queue.push_back(read_item(15, 11));
      draw_queue.push_back(read_item(16, 0));
      draw_queue.push_back(read_item(255, 255));
      draw_queue.push_back(read_item(5, 3));
      draw_queue.push_back(read_item(0, 8));

      configure(rcr_pkg::MAX_SIDE, rcr_pkg::MAX_SIDE, 8'h2E);
      draw_queue.push_back(clear_item());
      draw_queue.push_back(rect_item(rcr_pkg::OP_OUTLINE, 0, 0, rcr_pkg::MAX_SIDE * FRAC_ONE,
                                     rcr_pkg::MAX_SIDE * FRAC_ONE, 8'h52));
      draw_queue.push_back(read_item(255, 255));
      draw_queue.push_back(read_item(0, 255));
      draw_queue.push_back(read_item(128, 0));

      for (p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 8) begin
            cols = phase_cols[p];
            rows = phase_rows[p];
         end else begin
            cols = $urandom_range(1, 24);
            rows = $urandom_range(1, 24);
         end
         bg = (p == 1) ? 0 : (p == 2) ? 255 : $urandom_range(0, 255);
         configure(cols, rows, bg);
         draw_queue.push_back(clear_item());
         for (k = 1; k < ITEMS_PER_PHASE; k++)
            draw_queue.push_back(random_item(int'(side_in_use(cols_reg)),
                                             int'(side_in_use(rows_reg))));
      end

      drain();
      repeat (200) @(posedge clock);
      if (failures == 0 && expected_pixels.size() == 0)
         $display("PASS rectangle_canvas_rasterizer_unit");
      else
         $display("FAIL rectangle_canvas_rasterizer_unit");
      $finish;
   end

endmodule
